// ===== rtl/core/cts_pkg.sv =====
// Shared types and constants for the connection transport sequencer.
// No dependencies; imported by every module of the block.
package cts_pkg;

   // Request queue depth and the width of the count of unsent requests
   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Result queue sizing (up to two beats in per event, one out per cycle while rsp_ready is high)
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   // Configuration register indexes
   localparam logic [1:0] CSR_IDLE_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_ACK_TIMEOUT  = 2'd1;
   localparam logic [1:0] CSR_MAX_REPEATS  = 2'd2;

   // Configuration reset values
   localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd6000;
   localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd3000;
   localparam logic [2:0]  MAX_REPEATS_RST  = 3'd3;

   typedef enum logic [3:0] {
      OP_START      = 4'd0,
      OP_RX_DISC    = 4'd1,
      OP_RX_CONNECT = 4'd2,
      OP_RX_DATA    = 4'd3,
      OP_RX_NACK    = 4'd4,
      OP_RX_ACK     = 4'd5,
      OP_RX_OTHER   = 4'd6,
      OP_SEND_REQ   = 4'd7,
      OP_TICK       = 4'd8,
      OP_STOP       = 4'd9
   } opcode_type;

   typedef enum logic [2:0] {
      ACT_CONNECT    = 3'd0,
      ACT_DISCONNECT = 3'd1,
      ACT_ACK        = 3'd2,
      ACT_DATA       = 3'd3,
      ACT_DELIVER    = 3'd4,
      ACT_END        = 3'd5,
      ACT_DROPPED    = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      MODE_CLOSED = 2'd0,
      MODE_IDLE   = 2'd1,
      MODE_WAIT   = 2'd2
   } mode_type;

   // One result beat
   typedef struct packed {
      action_type  action;
      logic [3:0]  seq_out;
      logic [1:0]  delivered_byte;
      logic        last;
   } rsp_type;

   // Results produced by one event, handed to the result queue
   typedef struct packed {
      logic [1:0] count;
      rsp_type    r0;
      rsp_type    r1;
   } push_type;

   function automatic rsp_type mk_rsp(action_type act, logic [3:0] seq, logic [1:0] byte_v);
      rsp_type r;
      r.action         = act;
      r.seq_out        = seq;
      r.delivered_byte = byte_v;
      r.last           = 1'b0;
      return r;
   endfunction

endpackage

// ===== rtl/core/cts_engine.sv =====
// Connection state, configuration registers and the per-event decision logic.
// Depends on cts_pkg.
module cts_engine
   import cts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  logic [3:0]  opcode,
   input  logic [3:0]  rx_seq,
   input  logic [7:0]  rx_first_byte,
   input  logic        deliver_room,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output push_type    push
);

   // configuration
   logic [15:0] idle_to_ff, ack_to_ff;
   logic [2:0]  max_rep_ff;

   // connection state
   mode_type         mode_ff, mode_in;
   logic [3:0]       send_seq_ff, send_seq_in;
   logic [3:0]       recv_seq_ff, recv_seq_in;
   logic [2:0]       rep_ff, rep_in;
   logic [15:0]      timer_ff, timer_in;
   logic [CNT_W-1:0] unsent_ff, unsent_in;
   logic             await_ff, await_in;

   // decision scratch
   opcode_type     op;
   logic           open;
   logic           do_close, do_repeat, do_send;
   logic [3:0]     prev_seq;
   logic [CNT_W:0] occupancy;
   logic [1:0]     n;
   rsp_type        res [2];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_to_ff <= IDLE_TIMEOUT_RST;
         ack_to_ff  <= ACK_TIMEOUT_RST;
         max_rep_ff <= MAX_REPEATS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IDLE_TIMEOUT: idle_to_ff <= csr_wdata;
            CSR_ACK_TIMEOUT:  ack_to_ff  <= csr_wdata;
            CSR_MAX_REPEATS:  max_rep_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_CLOSED;
         send_seq_ff <= '0;
         recv_seq_ff <= '0;
         rep_ff      <= '0;
         timer_ff    <= '0;
         unsent_ff   <= '0;
         await_ff    <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         send_seq_ff <= send_seq_in;
         recv_seq_ff <= recv_seq_in;
         rep_ff      <= rep_in;
         timer_ff    <= timer_in;
         unsent_ff   <= unsent_in;
         await_ff    <= await_in;
      end
   end

   // next state and result beats for the event in the input register
   always_comb begin
      mode_in     = mode_ff;
      send_seq_in = send_seq_ff;
      recv_seq_in = recv_seq_ff;
      rep_in      = rep_ff;
      timer_in    = timer_ff;
      unsent_in   = unsent_ff;
      await_in    = await_ff;
      do_close    = 1'b0;
      do_repeat   = 1'b0;
      do_send     = 1'b0;
      n           = 2'd0;
      res[0]      = mk_rsp(ACT_CONNECT, 4'd0, 2'd0);
      res[1]      = mk_rsp(ACT_CONNECT, 4'd0, 2'd0);
      op          = opcode_type'(opcode);
      open        = (mode_ff != MODE_CLOSED);
      prev_seq    = recv_seq_ff - 4'd1;
      occupancy   = {1'b0, unsent_ff} + {{CNT_W{1'b0}}, await_ff};

      if (fire) begin
         // primary event handling
         if (op == OP_START) begin
            if (!open) begin
               mode_in     = MODE_IDLE;
               send_seq_in = '0;
               recv_seq_in = '0;
               rep_in      = '0;
               timer_in    = idle_to_ff;
               res[n[0]]   = mk_rsp(ACT_CONNECT, 4'd0, 2'd0);
               n           = n + 2'd1;
               do_send     = 1'b1;
            end
         end else if (op == OP_SEND_REQ) begin
            if (occupancy >= (CNT_W+1)'(QUEUE_DEPTH)) begin
               res[n[0]] = mk_rsp(ACT_DROPPED, 4'd0, 2'd0);
               n         = n + 2'd1;
            end else begin
               unsent_in = unsent_ff + CNT_W'(1);
               do_send   = 1'b1;
            end
         end else if (open) begin
            unique case (op)
               OP_RX_DISC, OP_RX_CONNECT, OP_STOP: do_close = 1'b1;
               OP_RX_DATA: begin
                  if (rx_seq == recv_seq_ff) begin
                     if (deliver_room) begin
                        res[0]      = mk_rsp(ACT_DELIVER, 4'd0, rx_first_byte[1:0]);
                        res[1]      = mk_rsp(ACT_ACK, recv_seq_ff, 2'd0);
                        n           = 2'd2;
                        recv_seq_in = recv_seq_ff + 4'd1;
                     end
                     if (mode_ff == MODE_IDLE) timer_in = idle_to_ff;
                  end else if (rx_seq == prev_seq) begin
                     res[0] = mk_rsp(ACT_ACK, rx_seq, 2'd0);
                     n      = 2'd1;
                     if (mode_ff == MODE_IDLE) timer_in = idle_to_ff;
                  end else begin
                     do_close = 1'b1;
                  end
               end
               OP_RX_NACK: begin
                  if (rx_seq == send_seq_ff && mode_ff == MODE_WAIT && await_ff &&
                      rep_ff < max_rep_ff) begin
                     do_repeat = 1'b1;
                  end else begin
                     do_close = 1'b1;
                  end
               end
               OP_RX_ACK: begin
                  if (rx_seq == send_seq_ff && mode_ff == MODE_WAIT) begin
                     timer_in    = idle_to_ff;
                     mode_in     = MODE_IDLE;
                     await_in    = 1'b0;
                     send_seq_in = send_seq_ff + 4'd1;
                     do_send     = 1'b1;
                  end else begin
                     do_close = 1'b1;
                  end
               end
               OP_TICK: begin
                  if (timer_ff > 16'd1) begin
                     timer_in = timer_ff - 16'd1;
                  end else begin
                     timer_in = '0;
                     if (mode_ff == MODE_WAIT && rep_ff < max_rep_ff) do_repeat = 1'b1;
                     else do_close = 1'b1;
                  end
               end
               default: ;
            endcase
         end

         // close the link: disconnect, then end marker if there is room
         if (do_close) begin
            mode_in   = MODE_CLOSED;
            await_in  = 1'b0;
            timer_in  = '0;
            res[n[0]] = mk_rsp(ACT_DISCONNECT, 4'd0, 2'd0);
            n         = n + 2'd1;
            if (deliver_room) begin
               res[n[0]] = mk_rsp(ACT_END, 4'd0, 2'd0);
               n         = n + 2'd1;
            end
         end

         // repeat the unacknowledged frame
         if (do_repeat) begin
            rep_in    = rep_ff + 3'd1;
            timer_in  = ack_to_ff;
            res[n[0]] = mk_rsp(ACT_DATA, send_seq_ff, 2'd0);
            n         = n + 2'd1;
         end

         // send the next queued request when idle
         if (do_send && mode_in == MODE_IDLE && unsent_in != '0) begin
            unsent_in = unsent_in - CNT_W'(1);
            await_in  = 1'b1;
            rep_in    = '0;
            mode_in   = MODE_WAIT;
            timer_in  = ack_to_ff;
            res[n[0]] = mk_rsp(ACT_DATA, send_seq_in, 2'd0);
            n         = n + 2'd1;
         end
      end

      // mark the final beat of this event
      res[0].last = (n == 2'd1);
      res[1].last = 1'b1;
      push.count  = n;
      push.r0     = res[0];
      push.r1     = res[1];
   end

endmodule

// ===== rtl/core/cts_rsp_queue.sv =====
// Result queue: takes up to two beats per event, hands out one beat per cycle while rsp_ready is high.
// Depends on cts_pkg.
module cts_rsp_queue
   import cts_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_beat
);

   rsp_type             entry_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0] count_ff, count_in;
   logic                pop;

   // room for a full event's worth of beats
   assign room      = (count_ff <= RQ_CNT_W'(RQ_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_beat  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RQ_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + RQ_PTR_W'(pop);
      count_in  = count_ff + RQ_CNT_W'(push.count) - RQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry writes
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.r0;
      if (push.count == 2'd2) entry_ff[wr_ptr_ff + RQ_PTR_W'(1)] <= push.r1;
   end

endmodule

// ===== rtl/core/connection_transport_sequencer_top.sv =====
// Top level of the connection transport sequencer: input register, engine, result queue.
// Depends on cts_pkg, cts_engine and cts_rsp_queue.
//
// One event per cycle while the result queue has room: an accepted event lands in an input
// register and is decided by the engine once the queue has room for its beats; the engine
// updates the connection state and queues zero, one or two result beats in a four-entry
// result queue. Events are taken back to back as long as the queue has room for two beats;
// results leave at one beat per cycle while rsp_ready is high, so a stream of events that
// each cause two beats is throttled to the rate at which its beats leave. Configuration writes
// take effect at the next edge and are expected only while no event is in flight.
module connection_transport_sequencer_top
   import cts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_opcode,
   input  logic [3:0]  req_rx_seq,
   input  logic [7:0]  req_rx_first_byte,
   input  logic        req_deliver_room,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_action,
   output logic [3:0]  rsp_seq_out,
   output logic [1:0]  rsp_delivered_byte,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic       in_valid_ff;
   logic [3:0] opcode_ff, rx_seq_ff;
   logic [7:0] first_byte_ff;
   logic       room_bit_ff;
   logic       fire, room;
   push_type   push;
   rsp_type    rsp_beat;

   // the held event is decided when the result queue can take its beats
   assign fire      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else if (req_ready) in_valid_ff <= req_valid;
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         opcode_ff     <= req_opcode;
         rx_seq_ff     <= req_rx_seq;
         first_byte_ff <= req_rx_first_byte;
         room_bit_ff   <= req_deliver_room;
      end
   end

   cts_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .opcode        (opcode_ff),
      .rx_seq        (rx_seq_ff),
      .rx_first_byte (first_byte_ff),
      .deliver_room  (room_bit_ff),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .push          (push)
   );

   cts_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

   assign rsp_action         = rsp_beat.action;
   assign rsp_seq_out        = rsp_beat.seq_out;
   assign rsp_delivered_byte = rsp_beat.delivered_byte;
   assign rsp_last           = rsp_beat.last;

endmodule
